[hdl/hsk_pkg.sv]
// Package for the Hilbert sort key generator.
// Holds the request/result payload types, configuration types and register codes.
// No dependencies; every other file of the block imports it.
`default_nettype none

package hsk_pkg;

    // Widths fixed by the data formats.
    localparam int unsigned HSK_FIX_W        = 32;
    localparam int unsigned HSK_COORD_W      = 16;
    localparam int unsigned HSK_KEY_W        = 32;
    localparam int unsigned HSK_SORT_W       = 33;
    // The curve is encoded in two halves of equal depth.
    localparam int unsigned HSK_CURVE_ORDER  = 16;
    localparam int unsigned HSK_LEVELS_STAGE = HSK_CURVE_ORDER / 2;
    localparam int unsigned HSK_DIGITS_W     = 2 * HSK_LEVELS_STAGE;
    localparam int unsigned HSK_ADDR_W       = 4;
    localparam int unsigned HSK_DATA_W       = 32;

    // Register indexes (paddr[3:2]).
    typedef enum logic [1:0] {
        CFG_X_ORIGIN = 2'd0,
        CFG_Y_ORIGIN = 2'd1,
        CFG_X_SCALE  = 2'd2,
        CFG_Y_SCALE  = 2'd3
    } t_cfg_idx;

    // Input request payload.
    typedef struct packed {
        logic signed [HSK_FIX_W-1:0] centroid_x;
        logic signed [HSK_FIX_W-1:0] centroid_y;
        logic                        is_quad;
    } t_in_req;

    // Result payload.
    typedef struct packed {
        logic [HSK_KEY_W-1:0]   hilbert_key;
        logic [HSK_COORD_W-1:0] quant_x;
        logic [HSK_COORD_W-1:0] quant_y;
        logic [HSK_SORT_W-1:0]  sort_key;
    } t_out_res;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic signed [HSK_FIX_W-1:0] x_origin;
        logic signed [HSK_FIX_W-1:0] y_origin;
        logic [HSK_FIX_W-1:0]        x_scale;
        logic [HSK_FIX_W-1:0]        y_scale;
    } t_cfg;

    // Orientation of the remaining sub-square on the Hilbert curve.
    typedef struct packed {
        logic swap;
        logic inv;
    } t_hil_state;

endpackage

`default_nettype wire

[hdl/hsk_cfg_regs.sv]
// Configuration register file of the Hilbert sort key generator (APB-style port).
// Depends on hsk_pkg for the register codes and the configuration struct.
`default_nettype none

module hsk_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [hsk_pkg::HSK_ADDR_W-1:0]   paddr,
    input  wire logic [hsk_pkg::HSK_DATA_W-1:0]   pwdata,
    output logic      [hsk_pkg::HSK_DATA_W-1:0]   prdata,
    output logic                                  pready,
    output hsk_pkg::t_cfg                         o_cfg
);
    import hsk_pkg::*;

    t_cfg     r_cfg;
    t_cfg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_cfg_idx'(paddr[HSK_ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Register writes in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                CFG_X_ORIGIN: r_cfg.x_origin <= pwdata;
                CFG_Y_ORIGIN: r_cfg.y_origin <= pwdata;
                CFG_X_SCALE:  r_cfg.x_scale  <= pwdata;
                CFG_Y_SCALE:  r_cfg.y_scale  <= pwdata;
                default:      r_cfg          <= r_cfg;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        unique case (w_idx)
            CFG_X_ORIGIN: prdata = r_cfg.x_origin;
            CFG_Y_ORIGIN: prdata = r_cfg.y_origin;
            CFG_X_SCALE:  prdata = r_cfg.x_scale;
            CFG_Y_SCALE:  prdata = r_cfg.y_scale;
            default:      prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[hdl/hsk_hilbert_step.sv]
// Eight levels of the Hilbert xy-to-d transform, most significant level first.
// Depends on hsk_pkg for the orientation state type and level count.
`default_nettype none

module hsk_hilbert_step (
    input  wire logic [hsk_pkg::HSK_LEVELS_STAGE-1:0] i_x_bits,
    input  wire logic [hsk_pkg::HSK_LEVELS_STAGE-1:0] i_y_bits,
    input  wire hsk_pkg::t_hil_state                   i_state,
    output logic      [hsk_pkg::HSK_DIGITS_W-1:0]     o_digits,
    output hsk_pkg::t_hil_state                        o_state
);
    import hsk_pkg::*;

    // Each level maps the oriented (rx, ry) bit pair to a base-4 digit and then
    // updates the orientation: a lower-left quadrant swaps the axes, a
    // lower-right quadrant also reflects both.
    always_comb begin
        t_hil_state st;
        logic       ex;
        logic       ey;
        st       = i_state;
        o_digits = '0;
        for (int i = HSK_LEVELS_STAGE - 1; i >= 0; i--) begin
            ex = st.inv ^ (st.swap ? i_y_bits[i] : i_x_bits[i]);
            ey = st.inv ^ (st.swap ? i_x_bits[i] : i_y_bits[i]);
            o_digits[2*i +: 2] = {ex, ex ^ ey};
            if (!ey) begin
                if (ex) begin
                    st.inv = !st.inv;
                end
                st.swap = !st.swap;
            end
        end
        o_state = st;
    end

endmodule

`default_nettype wire

[hdl/hilbert_sort_key_generator_top.sv]
// Hilbert sort key generator: four-stage pipeline with offset, scale, clamp and
// Hilbert encoding. The result is driven straight from the fourth stage register.
// Throughput is one request per cycle unless the result side stalls; each stage holds
// its data under stall and accepts new data as soon as the next stage frees up, so
// bubbles are squeezed out.
// Synchronous active-low reset clears all stage valids and the configuration to 0.
// Depends on hsk_pkg, hsk_cfg_regs and hsk_hilbert_step.
`default_nettype none

module hilbert_sort_key_generator_top (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Request channel
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire hsk_pkg::t_in_req                 i_in_data,
    // Result channel
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output hsk_pkg::t_out_res                     o_out_data,
    // Configuration port
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [hsk_pkg::HSK_ADDR_W-1:0]   paddr,
    input  wire logic [hsk_pkg::HSK_DATA_W-1:0]   pwdata,
    output logic      [hsk_pkg::HSK_DATA_W-1:0]   prdata,
    output logic                                  pready
);
    import hsk_pkg::*;

    t_cfg w_cfg;

    hsk_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Stage valids and flow control: a stage may load when it is empty or
    // its content moves on in the same cycle.
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    assign w_rdy4      = !r_v4 || !i_out_stall;
    assign w_rdy3      = !r_v3 || w_rdy4;
    assign w_rdy2      = !r_v2 || w_rdy3;
    assign w_rdy1      = !r_v1 || w_rdy2;
    assign o_in_stall  = !w_rdy1;
    assign o_out_valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_in_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    // Stage 1: offset from the origin; a difference at or below zero becomes 0.
    // A positive difference always fits in 32 unsigned bits.
    logic signed [HSK_FIX_W:0] w_diff_x, w_diff_y;
    logic [HSK_FIX_W-1:0]      n_dx, n_dy;
    logic [HSK_FIX_W-1:0]      r_dx, r_dy;
    logic                      r_quad1;

    assign w_diff_x = {i_in_data.centroid_x[HSK_FIX_W-1], i_in_data.centroid_x}
                    - {w_cfg.x_origin[HSK_FIX_W-1], w_cfg.x_origin};
    assign w_diff_y = {i_in_data.centroid_y[HSK_FIX_W-1], i_in_data.centroid_y}
                    - {w_cfg.y_origin[HSK_FIX_W-1], w_cfg.y_origin};
    assign n_dx = w_diff_x[HSK_FIX_W] ? '0 : w_diff_x[HSK_FIX_W-1:0];
    assign n_dy = w_diff_y[HSK_FIX_W] ? '0 : w_diff_y[HSK_FIX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_dx    <= n_dx;
            r_dy    <= n_dy;
            r_quad1 <= i_in_data.is_quad;
        end
    end

    // Stage 2: Q16.16 times Q16.16 scale; keep the integer part of the Q32.32 product.
    // A zero scale yields a zero product on its own.
    logic [2*HSK_FIX_W-1:0] w_prod_x, w_prod_y;
    logic [HSK_FIX_W-1:0]   r_ipx, r_ipy;
    logic                   r_quad2;

    assign w_prod_x = r_dx * w_cfg.x_scale;
    assign w_prod_y = r_dy * w_cfg.y_scale;

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_ipx   <= w_prod_x[2*HSK_FIX_W-1:HSK_FIX_W];
            r_ipy   <= w_prod_y[2*HSK_FIX_W-1:HSK_FIX_W];
            r_quad2 <= r_quad1;
        end
    end

    // Stage 3: saturate to the grid and encode the upper eight curve levels.
    logic [HSK_COORD_W-1:0]  n_qx, n_qy;
    logic [HSK_DIGITS_W-1:0] w_dig_hi;
    t_hil_state              w_st_hi;
    logic [HSK_COORD_W-1:0]  r_qx, r_qy;
    logic [HSK_DIGITS_W-1:0] r_dig_hi;
    t_hil_state              r_st3;
    logic                    r_quad3;

    assign n_qx = (|r_ipx[HSK_FIX_W-1:HSK_COORD_W]) ? '1 : r_ipx[HSK_COORD_W-1:0];
    assign n_qy = (|r_ipy[HSK_FIX_W-1:HSK_COORD_W]) ? '1 : r_ipy[HSK_COORD_W-1:0];

    hsk_hilbert_step u_hil_hi (
        .i_x_bits (n_qx[HSK_COORD_W-1:HSK_LEVELS_STAGE]),
        .i_y_bits (n_qy[HSK_COORD_W-1:HSK_LEVELS_STAGE]),
        .i_state  ('0),
        .o_digits (w_dig_hi),
        .o_state  (w_st_hi)
    );

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_qx     <= n_qx;
            r_qy     <= n_qy;
            r_dig_hi <= w_dig_hi;
            r_st3    <= w_st_hi;
            r_quad3  <= r_quad2;
        end
    end

    // Stage 4: lower eight curve levels and result assembly.
    logic [HSK_DIGITS_W-1:0] w_dig_lo;
    t_hil_state              w_st_lo;
    t_out_res                n_out;
    t_out_res                r_out;

    hsk_hilbert_step u_hil_lo (
        .i_x_bits (r_qx[HSK_LEVELS_STAGE-1:0]),
        .i_y_bits (r_qy[HSK_LEVELS_STAGE-1:0]),
        .i_state  (r_st3),
        .o_digits (w_dig_lo),
        .o_state  (w_st_lo)
    );

    always_comb begin
        n_out.hilbert_key = {r_dig_hi, w_dig_lo};
        n_out.quant_x     = r_qx;
        n_out.quant_y     = r_qy;
        n_out.sort_key    = {r_quad3, r_dig_hi, w_dig_lo};
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r_out <= n_out;
        end
    end

    assign o_out_data = r_out;

    // The final orientation is not needed once the last level is encoded.
    logic w_unused;
    assign w_unused = ^w_st_lo;

    // An accepted request always lands in the first stage.
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_v1)
        else $error("accepted request did not enter stage 1");

    // An empty pipeline never stalls the request side.
    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_v1 && !r_v2 && !r_v3 && !r_v4) |-> !o_in_stall)
        else $error("stall raised with an empty pipeline");

    // A stalled result must keep the item behind it in stage 3.
    a_hold_stage3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_v4 && i_out_stall) |=> r_v3)
        else $error("stage 3 item lost under result stall");

endmodule

`default_nettype wire
